/* src/prnc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prnc_pkg: shared types and constants for the periodic neighbour counter
// Request and result structs, controller/datapath command and status groups,
// controller state encoding, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package prnc_pkg;

    localparam int MAX_AGENTS_DEF = 1024;

    localparam int COORD_W = 32;
    localparam int TOTAL_W = 11;
    localparam int SUM_W   = 21;
    localparam int MEAN_W  = 19;

    // Q.8 scaling of the mean
    localparam int FRAC_W = 8;

    typedef logic [1:0] cfg_index_t;

    localparam cfg_index_t CFG_BOX_WIDTH  = 2'd0;
    localparam cfg_index_t CFG_BOX_HEIGHT = 2'd1;
    localparam cfg_index_t CFG_RADIUS     = 2'd2;

    localparam logic [COORD_W-1:0] BOX_WIDTH_RST  = 32'd6553600;
    localparam logic [COORD_W-1:0] BOX_HEIGHT_RST = 32'd6553600;
    localparam logic [COORD_W-1:0] RADIUS_RST     = 32'd65536;

    typedef struct packed {
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic               last_agent;
    } agent_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] agent_total;
        logic [SUM_W-1:0]   neighbour_sum;
        logic [MEAN_W-1:0]  mean_neighbours;
    } result_t;

    typedef struct packed {
        logic load;
        logic pair_init;
        logic pair_issue;
        logic div_start;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic few_agents;
        logic last_pair;
        logic pipe_idle;
        logic div_done;
    } stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_PAIR,
        ST_DRAIN,
        ST_DIVIDE
    } state_t;

endpackage

/* src/prnc_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prnc_div: restoring divider, one quotient bit per cycle
// Divides a DW-bit dividend by a CW-bit divisor.
// ----------------------------------------------------------------------------
module prnc_div #(
    parameter int DW = 31,
    parameter int CW = 11
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [CW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);
    import prnc_pkg::*;

    localparam int NW = $clog2(DW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [NW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic [CW:0]   trial;
    logic          fits;

    assign trial = {rem_reg, quo_reg[DW-1]};
    assign fits  = (trial >= {1'b0, divisor});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = NW'(DW);
            quo_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract when the divisor fits
            rem_next = fits ? CW'(trial - {1'b0, divisor}) : trial[CW-1:0];
            quo_next = {quo_reg[DW-2:0], fits};
            cnt_next = cnt_reg - NW'(1);
            if (cnt_reg == NW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

`ifndef SYNTHESIS
    a_div_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg && !done_reg)
        else $error("divider not busy after start");
`endif

endmodule

/* src/prnc_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prnc_dp: position store, pair test pipeline, counters and result register
// Stores agent positions, walks the pair indexes, tests one pair per cycle
// and counts close pairs, then forms the sum and mean of the snapshot.
// ----------------------------------------------------------------------------
module prnc_dp #(
    parameter int MAX_AGENTS = prnc_pkg::MAX_AGENTS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  prnc_pkg::cmd_t                       cmd,
    output prnc_pkg::stat_t                      stat,
    input  prnc_pkg::agent_t                     agent,
    input  logic [prnc_pkg::COORD_W-1:0]         box_width,
    input  logic [prnc_pkg::COORD_W-1:0]         box_height,
    input  logic [prnc_pkg::COORD_W-1:0]         interaction_radius,
    output logic                                 done,
    output prnc_pkg::result_t                    result
);
    import prnc_pkg::*;

    localparam int AW = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1;
    localparam int CW = $clog2(MAX_AGENTS + 1);
    localparam int PW = 2 * CW;
    localparam int SW = PW + 1;
    localparam int DW = SW + FRAC_W;
    localparam int XW = DW + SUM_W;
    localparam int VW = 6;

    function automatic logic signed [33:0] wrap_axis(
        input logic signed [33:0]  d,
        input logic [COORD_W-1:0]  len
    );
        logic signed [34:0] twice;
        logic signed [34:0] len_s;
        logic signed [33:0] len_d;
        logic signed [33:0] res;
        twice = {d, 1'b0};
        len_s = $signed({3'b000, len});
        len_d = $signed({2'b00, len});
        if (twice > len_s)
            res = d - len_d;
        else if (twice < -len_s)
            res = d + len_d;
        else
            res = d;
        return res;
    endfunction

    // position store
    logic [COORD_W-1:0] x_mem [MAX_AGENTS];
    logic [COORD_W-1:0] y_mem [MAX_AGENTS];

    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] i_reg, i_next;
    logic [AW-1:0] j_reg, j_next;
    logic [PW-1:0] pairs_reg, pairs_next;
    logic [VW-1:0] vld_reg;
    logic          store_ok;
    logic          j_end;

    // pipeline payload
    logic [COORD_W-1:0]  xa_reg, xb_reg, ya_reg, yb_reg;
    logic signed [33:0]  dx_reg, dy_reg;
    logic signed [33:0]  wx_reg, wy_reg;
    logic signed [33:0]  nx, ny;
    logic [COORD_W-1:0]  ax_reg, ay_reg;
    logic [63:0]         sx_reg, sy_reg, r2_reg;
    logic [64:0]         d2;
    logic                close_reg;

    // divide and result
    logic [SW-1:0] sum_w;
    logic [SW-1:0] sum_reg;
    logic [DW-1:0] quotient;
    logic          div_done;
    logic [XW-1:0] n_ext, sum_ext, mean_ext;
    result_t       result_reg;
    logic          done_reg;

    assign store_ok = (count_reg < CW'(MAX_AGENTS));
    assign j_end    = (CW'(j_reg) == count_reg - CW'(1));

    // ---- counters
    always_comb
    begin
        count_next = count_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        pairs_next = pairs_reg;
        if (cmd.load && store_ok)
            count_next = count_reg + CW'(1);
        if (cmd.finish)
            count_next = '0;
        if (cmd.pair_init)
        begin
            i_next     = '0;
            j_next     = AW'(1);
            pairs_next = '0;
        end
        else if (cmd.pair_issue)
        begin
            if (j_end)
            begin
                i_next = i_reg + AW'(1);
                j_next = i_reg + AW'(2);
            end
            else
                j_next = j_reg + AW'(1);
        end
        if (vld_reg[VW-1] && close_reg)
            pairs_next = pairs_reg + PW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            i_reg     <= '0;
            j_reg     <= AW'(1);
            pairs_reg <= '0;
            vld_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            pairs_reg <= pairs_next;
            vld_reg   <= {vld_reg[VW-2:0], cmd.pair_issue};
            done_reg  <= cmd.finish;
        end
    end

    // ---- memory write and paired read
    always_ff @(posedge clk)
    begin
        if (cmd.load && store_ok)
        begin
            x_mem[count_reg[AW-1:0]] <= agent.pos_x;
            y_mem[count_reg[AW-1:0]] <= agent.pos_y;
        end
        if (cmd.pair_issue)
        begin
            xa_reg <= x_mem[i_reg];
            xb_reg <= x_mem[j_reg];
            ya_reg <= y_mem[i_reg];
            yb_reg <= y_mem[j_reg];
        end
    end

    // ---- pair test pipeline
    assign nx = -wx_reg;
    assign ny = -wy_reg;
    assign d2 = {1'b0, sx_reg} + {1'b0, sy_reg};

    always_ff @(posedge clk)
    begin
        dx_reg    <= $signed({2'b00, xb_reg}) - $signed({2'b00, xa_reg});
        dy_reg    <= $signed({2'b00, yb_reg}) - $signed({2'b00, ya_reg});
        wx_reg    <= wrap_axis(dx_reg, box_width);
        wy_reg    <= wrap_axis(dy_reg, box_height);
        ax_reg    <= wx_reg[33] ? nx[COORD_W-1:0] : wx_reg[COORD_W-1:0];
        ay_reg    <= wy_reg[33] ? ny[COORD_W-1:0] : wy_reg[COORD_W-1:0];
        sx_reg    <= 64'(ax_reg) * 64'(ax_reg);
        sy_reg    <= 64'(ay_reg) * 64'(ay_reg);
        r2_reg    <= 64'(interaction_radius) * 64'(interaction_radius);
        // overflow past 64 bits is never close
        close_reg <= !d2[64] && (d2[63:0] <= r2_reg);
    end

    // ---- sum and mean
    assign sum_w = SW'(count_reg) + {pairs_reg, 1'b0};

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
            sum_reg <= sum_w;
        if (cmd.finish)
            result_reg <= result_t'{
                agent_total:     n_ext[TOTAL_W-1:0],
                neighbour_sum:   sum_ext[SUM_W-1:0],
                mean_neighbours: mean_ext[MEAN_W-1:0]
            };
    end

    prnc_div #(
        .DW(DW),
        .CW(CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend ({sum_w, FRAC_W'(0)}),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign n_ext    = XW'(count_reg);
    assign sum_ext  = XW'(sum_reg);
    assign mean_ext = XW'(quotient);

    assign stat.few_agents = (count_reg < CW'(2));
    assign stat.last_pair  = j_end && (CW'(i_reg) == count_reg - CW'(2));
    assign stat.pipe_idle  = ~|vld_reg;
    assign stat.div_done   = div_done;

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pair_issue |-> (j_reg > i_reg) && (CW'(j_reg) < count_reg))
        else $error("pair index out of order or out of range");

    a_drained_before_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> (vld_reg == '0) && !cmd.pair_issue)
        else $error("divider started with pair tests in flight");
`endif

endmodule

/* src/prnc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prnc_ctrl: snapshot sequencer
// Loads requests, runs the pair walk, drains the test pipeline, runs the
// divider and retires the result.
// ----------------------------------------------------------------------------
module prnc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            last_agent,
    output logic            busy,
    output prnc_pkg::cmd_t  cmd,
    input  prnc_pkg::stat_t stat
);
    import prnc_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (last_agent)
                        state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.pair_init = 1'b1;
                state_next    = stat.few_agents ? ST_DRAIN : ST_PAIR;
            end
            ST_PAIR:
            begin
                cmd.pair_issue = 1'b1;
                if (stat.last_pair)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (stat.pipe_idle)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (stat.div_done)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

`ifndef SYNTHESIS
    a_last_pair_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PAIR) && stat.last_pair |=> state_reg == ST_DRAIN)
        else $error("pair walk did not stop at the last pair");

    a_finish_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> !busy)
        else $error("controller still busy after result");
`endif

endmodule

/* src/periodic_radius_neighbour_count.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_radius_neighbour_count: fixed-radius neighbour count, periodic box
// Loads a snapshot of agent positions, counts close pairs under a single
// periodic wrap per axis, and reports total, neighbour sum and Q.8 mean.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                 Payload
// -------   ---------  ------------------------  ------------------------------
// request   in         start & !busy             agent   (pos_x, pos_y, last)
// result    out        done, one cycle, no stall result  (total, sum, mean)
// config    in         cfg_valid & cfg_ready     cfg_index, cfg_data
//
// A request without the last mark is stored and leaves busy low. A
// last-marked request with N >= 2 agents stored holds busy through a setup
// step, the pair walk (one pair test per cycle through the shared two-read
// position memory), the drain of the 6-stage test pipeline and the divider,
// which forms one quotient bit per cycle of a (2*CW + 9)-bit dividend
// (CW = clog2(MAX_AGENTS+1)). With a single agent the pair walk is skipped.
// Reset clears the controller, counters and configuration; the position
// memory is not cleared and needs no clearing pass, since only entries of the
// current snapshot are read. The receiver cannot stall: done pulses in the
// cycle in which busy falls and the result stays on the port until the
// next snapshot finishes.
//
module periodic_radius_neighbour_count #(
    parameter int MAX_AGENTS = prnc_pkg::MAX_AGENTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          start,
    output logic                          busy,
    input  prnc_pkg::agent_t              agent,
    // result channel
    output logic                          done,
    output prnc_pkg::result_t             result,
    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  prnc_pkg::cfg_index_t          cfg_index,
    input  logic [prnc_pkg::COORD_W-1:0]  cfg_data
);
    import prnc_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    logic [COORD_W-1:0] box_width_reg,  box_width_next;
    logic [COORD_W-1:0] box_height_reg, box_height_next;
    logic [COORD_W-1:0] radius_reg,     radius_next;
    logic               cfg_wr;

    // Configuration registers: always ready, writes are registered.
    // Indexes past the register list are dropped.
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_comb
    begin
        box_width_next  = box_width_reg;
        box_height_next = box_height_reg;
        radius_next     = radius_reg;
        if (cfg_wr)
        begin
            case (cfg_index)
                CFG_BOX_WIDTH:  box_width_next  = cfg_data;
                CFG_BOX_HEIGHT: box_height_next = cfg_data;
                CFG_RADIUS:     radius_next     = cfg_data;
                default:
                begin
                    box_width_next = box_width_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_width_reg  <= BOX_WIDTH_RST;
            box_height_reg <= BOX_HEIGHT_RST;
            radius_reg     <= RADIUS_RST;
        end
        else
        begin
            box_width_reg  <= box_width_next;
            box_height_reg <= box_height_next;
            radius_reg     <= radius_next;
        end
    end

    // Sequencer: owns busy, steps the datapath by command.
    prnc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .last_agent (agent.last_agent),
        .busy       (busy),
        .cmd        (cmd),
        .stat       (stat)
    );

    // Datapath: position store, pair test pipeline, divider, result register.
    prnc_dp #(
        .MAX_AGENTS(MAX_AGENTS)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .stat               (stat),
        .agent              (agent),
        .box_width          (box_width_reg),
        .box_height         (box_height_reg),
        .interaction_radius (radius_reg),
        .done               (done),
        .result             (result)
    );

`ifndef SYNTHESIS
    a_done_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");
`endif

endmodule
